[hdl/kts_pkg.sv]
// Package for the keyframe track sampler: sizes, codes and shared types.
// Used by every module of the block but kts_ram; depends on nothing.
`default_nettype none
package kts_pkg;
  localparam int MaxKeys = 64;
  localparam int AddrW = $clog2(MaxKeys);
  localparam int CntW = $clog2(MaxKeys + 1);
  localparam int FrameW = 24;
  localparam int ValW = 32;
  localparam int Lanes = 3;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [1:0] ORG_INTERP = 2'd0;
  localparam logic [1:0] ORG_PREV = 2'd1;
  localparam logic [1:0] ORG_NEXT = 2'd2;
  localparam logic [1:0] ORG_REF = 2'd3;

  typedef struct packed {
    logic start;
    logic angle;
    logic [24:0] t;
    logic [24:0] d;
  } lane_ctl_t;
endpackage
`default_nettype wire

[hdl/kts_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module kts_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/kts_lane.sv]
// One interpolation lane: product by multiply, then bit-serial division.
// Depends on kts_pkg.
`default_nettype none
module kts_lane
  import kts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lane_ctl_t        ctl,
  input  wire logic [ValW-1:0]  vp,
  input  wire logic [ValW-1:0]  vn,
  output logic                  done,
  output logic [ValW-1:0]       result
);
  localparam int ProdW = 59;
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL = 2'd1;
  localparam logic [1:0] P_DIV = 2'd2;
  localparam logic [1:0] P_OUT = 2'd3;

  logic [1:0] phase;
  logic [5:0] cnt;
  logic angle;
  logic neg;
  logic [33:0] mag;
  logic [24:0] t;
  logic [24:0] d;
  logic [ProdW-1:0] quo;
  logic [25:0] rem;
  logic [ValW-1:0] base;
  logic signed [33:0] delta;
  logic [16:0] da;
  logic [25:0] rem_sh;

  always_comb begin
    da = {1'b0, vn[15:0]} - {1'b0, vp[15:0]};
    if (ctl.angle) begin
      delta = 34'(signed'(da));
      if ($signed(da) > 17'sd32768) delta = delta - 34'sd65536;
      else if ($signed(da) < -17'sd32768) delta = delta + 34'sd65536;
    end else begin
      delta = 34'($signed(vn)) - 34'($signed(vp));
    end
    rem_sh = {rem[24:0], quo[ProdW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: if (ctl.start) begin
          angle <= ctl.angle;
          neg <= delta[33];
          mag <= delta[33] ? 34'(-delta) : 34'(delta);
          t <= ctl.t;
          d <= ctl.d;
          base <= ctl.angle ? {16'd0, vp[15:0]} : vp;
          phase <= P_MUL;
        end
        P_MUL: begin
          quo <= ProdW'(mag) * ProdW'(t);
          rem <= '0;
          cnt <= 6'(ProdW);
          phase <= P_DIV;
        end
        P_DIV: begin
          if (rem_sh >= {1'b0, d}) begin
            rem <= rem_sh - {1'b0, d};
            quo <= {quo[ProdW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[ProdW-2:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) phase <= P_OUT;
        end
        P_OUT: begin
          result <= angle
            ? {16'd0, 16'(base + (neg ? -quo[31:0] : quo[31:0]))}
            : base + (neg ? -quo[31:0] : quo[31:0]);
          done <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/keyframe_track_sampler_unit.sv]
// Top level of the keyframe track sampler: key table, scan, three lanes, merge.
// Depends on kts_pkg, kts_ram and kts_lane.
//
// Channel   Signals                                  Timing
// config    track_mode_we, track_mode_wdata          written at any edge with we
// item      start, busy, func, frame, key_*, ref_*   taken when start and !busy
// result    done, out_*, origin_kind, status         one cycle, no stall
//
// Append, clear and unused codes go through S_WDONE, which raises done. A sample
// reads one key per cycle over the serial scan, and then the lanes divide one
// quotient bit per cycle.
// Reset empties the table and sets linear scalar mode. Results cannot stall.
`default_nettype none
module keyframe_track_sampler_unit
  import kts_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                track_mode_we,
  input  wire logic [1:0]          track_mode_wdata,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          func,
  input  wire logic signed [23:0]  frame,
  input  wire logic signed [31:0]  key_x,
  input  wire logic signed [31:0]  key_y,
  input  wire logic signed [31:0]  key_z,
  input  wire logic signed [31:0]  ref_x,
  input  wire logic signed [31:0]  ref_y,
  input  wire logic signed [31:0]  ref_z,
  output logic                     done,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic [1:0]               origin_kind,
  output logic                     status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RDP = 3'd2;
  localparam logic [2:0] S_RDN = 3'd3;
  localparam logic [2:0] S_GO = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;
  localparam logic [2:0] S_WDONE = 3'd7;

  logic [2:0] state;
  logic [1:0] track_mode;
  logic [CntW-1:0] key_count;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] rd_idx;
  logic rd_valid;
  logic has_prev;
  logic [AddrW-1:0] prev;
  logic [AddrW-1:0] next;
  logic signed [23:0] q;
  logic signed [23:0] fp;
  logic [1:0] mode;
  logic [ValW-1:0] rx, ry, rz;
  logic [ValW-1:0] px, py, pz;
  logic [1:0] kind;

  logic we;
  logic [AddrW-1:0] addr;
  logic [FrameW-1:0] rf;
  logic [ValW-1:0] rvx, rvy, rvz;
  lane_ctl_t ctl;
  logic [Lanes-1:0] ldone;
  logic [ValW-1:0] lx, ly, lz;
  logic [ValW-1:0] vx, vy, vz;

  assign busy = (state != S_IDLE) || done;
  assign we = start && !busy && func == FUNC_APPEND && key_count != CntW'(MaxKeys);

  always_comb begin
    unique case (state)
      S_RDP: addr = prev;
      S_IDLE: addr = we ? key_count[AddrW-1:0] : '0;
      default: addr = idx[AddrW-1:0];
    endcase
    if (state == S_RDN) addr = next;
  end

  kts_ram #(.Width(FrameW), .Depth(MaxKeys)) u_f (
    .clk(clk), .we(we), .addr(addr), .wdata(frame), .rdata(rf));
  kts_ram #(.Width(ValW), .Depth(MaxKeys)) u_x (
    .clk(clk), .we(we), .addr(addr), .wdata(key_x), .rdata(rvx));
  kts_ram #(.Width(ValW), .Depth(MaxKeys)) u_y (
    .clk(clk), .we(we), .addr(addr), .wdata(key_y), .rdata(rvy));
  kts_ram #(.Width(ValW), .Depth(MaxKeys)) u_z (
    .clk(clk), .we(we), .addr(addr), .wdata(key_z), .rdata(rvz));

  kts_lane u_lx (.clk(clk), .rst(rst), .ctl(ctl), .vp(px), .vn(rvx),
    .done(ldone[0]), .result(lx));
  kts_lane u_ly (.clk(clk), .rst(rst), .ctl(ctl), .vp(py), .vn(rvy),
    .done(ldone[1]), .result(ly));
  kts_lane u_lz (.clk(clk), .rst(rst), .ctl(ctl), .vp(pz), .vn(rvz),
    .done(ldone[2]), .result(lz));

  always_comb begin
    ctl.start = (state == S_GO);
    ctl.angle = mode[1];
    ctl.t = 25'(q) - 25'(fp);
    ctl.d = 25'($signed(rf)) - 25'(fp);
    vx = mode[1] ? {16'd0, rvx[15:0]} : rvx;
    vy = mode[1] ? {16'd0, rvy[15:0]} : rvy;
    vz = mode[1] ? {16'd0, rvz[15:0]} : rvz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      track_mode <= 2'd0;
      key_count <= '0;
      done <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (track_mode_we) track_mode <= track_mode_wdata;
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start && !busy) begin
          out_x <= '0; out_y <= '0; out_z <= '0;
          origin_kind <= ORG_INTERP;
          status <= 1'b0;
          q <= frame; mode <= track_mode;
          rx <= ref_x; ry <= ref_y; rz <= ref_z;
          has_prev <= 1'b0;
          idx <= '0;
          rd_valid <= 1'b0;
          if (func == FUNC_APPEND) begin
            if (key_count != CntW'(MaxKeys)) key_count <= key_count + 1'b1;
            else status <= 1'b1;
            state <= S_WDONE;
          end else if (func == FUNC_CLEAR) begin
            key_count <= '0;
            state <= S_WDONE;
          end else if (func == FUNC_SAMPLE) begin
            state <= S_SCAN;
          end else begin
            state <= S_WDONE;
          end
        end
        S_WDONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (rd_valid && $signed(rf) > q) begin
            next <= rd_idx[AddrW-1:0];
            state <= has_prev ? S_RDP : S_RDN;
            kind <= has_prev ? ORG_INTERP : ORG_NEXT;
          end else begin
            if (rd_valid) begin
              has_prev <= 1'b1;
              prev <= rd_idx[AddrW-1:0];
            end
            if (idx < key_count) begin
              rd_idx <= idx;
              idx <= idx + 1'b1;
              rd_valid <= 1'b1;
            end else begin
              rd_valid <= 1'b0;
              if (rd_valid || has_prev) begin
                kind <= ORG_PREV;
                state <= S_RDP;
              end else begin
                out_x <= rx;
                out_y <= mode[0] ? ry : '0;
                out_z <= mode[0] ? rz : '0;
                origin_kind <= ORG_REF;
                done <= 1'b1;
                state <= S_IDLE;
              end
            end
          end
        end
        S_RDP: state <= (kind == ORG_INTERP) ? S_RDN : S_HOLD;
        S_RDN: begin
          if (kind == ORG_INTERP) begin
            fp <= rf; px <= rvx; py <= rvy; pz <= rvz;
            state <= S_GO;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          out_x <= vx;
          out_y <= mode[0] ? vy : '0;
          out_z <= mode[0] ? vz : '0;
          origin_kind <= kind;
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_GO: state <= S_WAIT;
        S_WAIT: if (&ldone) begin
          out_x <= lx;
          out_y <= mode[0] ? ly : '0;
          out_z <= mode[0] ? lz : '0;
          origin_kind <= ORG_INTERP;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/kts_checker.sv]
// Port-level checker for the keyframe track sampler, bound to the top level.
// Depends on kts_pkg and the top level's ports only.
`default_nettype none
module kts_port_assert
  import kts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] origin_kind,
  input wire logic       status
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after item");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for two cycles");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while not busy");
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    done && status |-> origin_kind == ORG_INTERP) else $error("dropped append with origin");
endmodule

bind keyframe_track_sampler_unit kts_port_assert u_kts_port_assert (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .origin_kind(origin_kind), .status(status));
`default_nettype wire

[tb/sv/kts_checker.sv]
// Checker for the keyframe track sampler: watches the item and result channels,
// predicts each result from its own key table and compares. Depends on kts_pkg.
`default_nettype none
module kts_checker
  import kts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               track_mode_we,
  input  wire logic [1:0]         track_mode_wdata,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         func,
  input  wire logic signed [23:0] frame,
  input  wire logic signed [31:0] key_x,
  input  wire logic signed [31:0] key_y,
  input  wire logic signed [31:0] key_z,
  input  wire logic signed [31:0] ref_x,
  input  wire logic signed [31:0] ref_y,
  input  wire logic signed [31:0] ref_z,
  input  wire logic               done,
  input  wire logic signed [31:0] out_x,
  input  wire logic signed [31:0] out_y,
  input  wire logic signed [31:0] out_z,
  input  wire logic [1:0]         origin_kind,
  input  wire logic               status,
  output int                      fail_count,
  output int                      pending
);
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0] org;
    logic st;
  } sample_t;

  sample_t expected_q[$];
  logic [1:0] mode;
  logic signed [23:0] tbl_frame[MaxKeys];
  logic signed [31:0] tbl_val[3][MaxKeys];
  int key_cnt;

  function automatic longint lerp_val(longint vp, longint vn, longint t, longint d,
                                      bit ang);
    longint a, b, delta, num, q;
    if (ang) begin
      a = vp & 16'hFFFF;
      b = vn & 16'hFFFF;
    end else begin
      a = vp;
      b = vn;
    end
    delta = b - a;
    if (ang && delta > 32768) delta -= 65536;
    else if (ang && delta < -32768) delta += 65536;
    num = delta * t;
    q = (num < 0) ? -((-num) / d) : num / d;
    return ang ? ((a + q) & 16'hFFFF) : a + q;
  endfunction

  function automatic sample_t track_result(logic [1:0] f, longint fr, longint kv[3],
                                           longint rv[3]);
    sample_t r;
    longint v[3];
    int prev, nxt, lanes, c, k;
    bit ang;
    r = '0;
    v = '{0, 0, 0};
    lanes = mode[0] ? 3 : 1;
    ang = mode[1];
    if (f == FUNC_APPEND) begin
      if (key_cnt < MaxKeys) begin
        tbl_frame[key_cnt] = 24'(fr);
        for (c = 0; c < 3; c++) tbl_val[c][key_cnt] = 32'(kv[c]);
        key_cnt++;
      end else begin
        r.st = 1'b1;
      end
    end else if (f == FUNC_CLEAR) begin
      key_cnt = 0;
    end else if (f == FUNC_SAMPLE) begin
      prev = -1;
      nxt = -1;
      for (k = 0; k < key_cnt; k++) begin
        if (tbl_frame[k] <= fr) prev = k;
        else begin
          nxt = k;
          break;
        end
      end
      if (prev >= 0 && nxt >= 0) begin
        r.org = ORG_INTERP;
        for (c = 0; c < lanes; c++)
          v[c] = lerp_val(tbl_val[c][prev], tbl_val[c][nxt], fr - tbl_frame[prev],
                          longint'(tbl_frame[nxt]) - tbl_frame[prev], ang);
      end else if (prev >= 0 || nxt >= 0) begin
        k = (prev >= 0) ? prev : nxt;
        r.org = (prev >= 0) ? ORG_PREV : ORG_NEXT;
        for (c = 0; c < lanes; c++)
          v[c] = ang ? (tbl_val[c][k] & 16'hFFFF) : tbl_val[c][k];
      end else begin
        r.org = ORG_REF;
        for (c = 0; c < lanes; c++) v[c] = rv[c];
      end
    end
    r.x = 32'(v[0]);
    r.y = 32'(v[1]);
    r.z = 32'(v[2]);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    sample_t got, want;
    longint kv[3], rv[3];
    if (rst) begin
      mode <= 2'd0;
      key_cnt = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        got = '{out_x, out_y, out_z, origin_kind, status};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected x %h y %h z %h org %0d st %0d", $time, want.x,
                     want.y, want.z, want.org, want.st);
            $display("%0t: actual   x %h y %h z %h org %0d st %0d", $time, got.x,
                     got.y, got.z, got.org, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        kv = '{key_x, key_y, key_z};
        rv = '{ref_x, ref_y, ref_z};
        expected_q = {expected_q, track_result(func, frame, kv, rv)};
      end
      if (track_mode_we) mode <= track_mode_wdata;
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench top for the keyframe track sampler: clock, reset and stimulus,
// with kts_checker beside the block. Depends on kts_pkg and the block's RTL.
`default_nettype none
module tb_top;
  import kts_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic track_mode_we = 1'b0;
  logic [1:0] track_mode_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = FUNC_CLEAR;
  logic signed [23:0] frame = '0;
  logic signed [31:0] key_x = '0, key_y = '0, key_z = '0;
  logic signed [31:0] ref_x = '0, ref_y = '0, ref_z = '0;
  logic done, status;
  logic signed [31:0] out_x, out_y, out_z;
  logic [1:0] origin_kind;
  int fail_count, pending;
  int cycles = 0;
  bit calm = 0;
  logic signed [23:0] last_frame = '0;

  localparam int CycleLimit = 1_500_000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyframe_track_sampler_unit i_dut (.*);
  kts_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("keyframe_track_sampler_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [1:0] f, logic signed [23:0] fr);
    while (!calm && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    frame <= fr;
    key_x <= rand_val();
    key_y <= rand_val();
    key_z <= rand_val();
    ref_x <= rand_val();
    ref_y <= rand_val();
    ref_z <= rand_val();
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    track_mode_we <= 1'b1;
    track_mode_wdata <= m;
    @(posedge clk);
    track_mode_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int i;
    for (i = 0; i < n; i++) begin
      calm = (i > n / 3 && i < n / 2);
      case ($urandom_range(0, 19))
        0: send_item(FUNC_CLEAR, 24'($urandom));
        1: send_item(FuncUnused, 24'($urandom));
        2, 3, 4, 5, 6: begin
          last_frame = 24'(last_frame + 24'($urandom_range(1, 1000)));
          send_item(FUNC_APPEND, ($urandom_range(0, 9) == 0) ? 24'($urandom)
                    : last_frame);
        end
        default: send_item(FUNC_SAMPLE, ($urandom_range(0, 9) == 0) ? 24'($urandom)
                           : 24'(last_frame - 24'($urandom_range(0, 3000)) + 24'sd200));
      endcase
      if ($urandom_range(0, 29) == 0)
        last_frame = 24'(int'($urandom_range(0, 1000)) - 500);
    end
    calm = 0;
  endtask

  initial begin
    int m, i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(FUNC_SAMPLE, 24'sh7FFFFF);
    send_item(FUNC_APPEND, 24'sh800000);
    send_item(FUNC_SAMPLE, 24'sh800000);
    send_item(FUNC_APPEND, 24'sh7FFFFF);
    send_item(FUNC_SAMPLE, 24'sh000000);
    send_item(FUNC_SAMPLE, 24'sh7FFFFF);
    send_item(FUNC_APPEND, 24'sh000100);
    send_item(FUNC_SAMPLE, 24'sh7FFFFE);
    send_item(FuncUnused, 24'sh123456);
    send_item(FUNC_CLEAR, '0);
    send_item(FUNC_APPEND, 24'sh000200);
    send_item(FUNC_SAMPLE, 24'sh000100);
    for (i = 0; i < 65; i++) send_item(FUNC_APPEND, 24'(i * 16));
    send_item(FUNC_SAMPLE, 24'sh000208);
    send_item(FUNC_SAMPLE, 24'sh7FFFFF);
    send_item(FUNC_CLEAR, '0);
    for (m = 0; m < 4; m++) begin
      set_mode(m[1:0]);
      send_item(FUNC_APPEND, 24'sh000010);
      send_item(FUNC_APPEND, 24'sh000090);
      send_item(FUNC_SAMPLE, 24'sh000050);
      send_item(FUNC_CLEAR, '0);
      send_item(FUNC_SAMPLE, 24'sh000050);
    end
    for (m = 0; m < 8; m++) begin
      set_mode((m < 4) ? m[1:0] : 2'($urandom_range(0, 3)));
      random_phase(78);
    end
    set_mode(2'd3);
    random_phase(40);
    drain();
    if (fail_count == 0)
      $display("keyframe_track_sampler_unit: match");
    else
      $display("keyframe_track_sampler_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/kts_pkg.sv
hdl/kts_ram.sv
hdl/kts_lane.sv
hdl/keyframe_track_sampler_unit.sv
hdl/kts_checker.sv
tb/sv/kts_checker.sv
tb/sv/tb_top.sv
